// ----- hdl/rlpa_pkg.sv -----
// Package for the reference-counted LRU page allocator.
// Holds sizing constants, mode and status codes, and the controller/datapath structs.
// No dependencies; every other file of the block uses it.
package rlpa_pkg;

  localparam int unsigned NUM_PAGES   = 256;
  localparam int unsigned STAMP_BITS  = 48;
  localparam int unsigned REF_BITS    = 8;
  localparam int unsigned PAGE_BITS   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned WORD_BITS   = REF_BITS + STAMP_BITS;
  localparam int unsigned MODE_BITS   = 2;
  localparam int unsigned INDEX_BITS  = 8;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TOUCH   = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_SHARE   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FREE  = 2'd1,
    STATUS_REL_FREE = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;   // capture the incoming transaction, restart the scan counter
    logic clr_step;   // write a zero entry at the counter, advance it
    logic scan_step;  // read the entry at the counter, advance it
    logic page_wr;    // update the addressed page, form its result
    logic alloc_wr;   // commit the chosen page, form the allocate result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_last;   // counter points at the last page
  } sts_t;

endpackage

// ----- hdl/rlpa_if.sv -----
// Handshake interfaces for the page allocator request and response channels.
// Depends on rlpa_pkg for field widths.
interface rlpa_req_if;
  logic                             valid;
  logic                             ready;
  logic [rlpa_pkg::MODE_BITS-1:0]   mode;
  logic [rlpa_pkg::INDEX_BITS-1:0]  page_index;
  logic                             reuse_stamp;

  modport source (output valid, output mode, output page_index, output reuse_stamp,
                  input ready);
  modport sink   (input valid, input mode, input page_index, input reuse_stamp,
                  output ready);
endinterface

interface rlpa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rlpa_pkg::INDEX_BITS-1:0]   granted_page;
  logic [rlpa_pkg::STATUS_BITS-1:0]  status;

  modport source (output valid, output granted_page, output status, input ready);
  modport sink   (input valid, input granted_page, input status, output ready);
endinterface

// ----- hdl/rlpa_datapath.sv -----
// Datapath of the page allocator: page table memory, stamp clock, scan tracking.
// Depends on rlpa_pkg; driven by rlpa_ctrl through cmd_t, reports through sts_t.
module rlpa_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlpa_pkg::cmd_t                    cmd_i,
  output rlpa_pkg::sts_t                    sts_o,
  input  logic [rlpa_pkg::MODE_BITS-1:0]    mode_i,
  input  logic [rlpa_pkg::INDEX_BITS-1:0]   page_index_i,
  input  logic                              reuse_stamp_i,
  output logic [rlpa_pkg::INDEX_BITS-1:0]   res_granted_o,
  output logic [rlpa_pkg::STATUS_BITS-1:0]  res_status_o
);

  localparam int unsigned PB = rlpa_pkg::PAGE_BITS;
  localparam int unsigned SB = rlpa_pkg::STAMP_BITS;
  localparam int unsigned RB = rlpa_pkg::REF_BITS;
  localparam int unsigned WB = rlpa_pkg::WORD_BITS;

  // Page table: reference count over last-use stamp
  logic [WB-1:0] mem_q [rlpa_pkg::NUM_PAGES];
  logic [WB-1:0] rdata_q;

  // Latched transaction
  logic [rlpa_pkg::MODE_BITS-1:0]  mode_q;
  logic [rlpa_pkg::INDEX_BITS-1:0] page_q;
  logic                            reuse_q;

  logic [SB-1:0] clock_q, clock_d;
  logic [PB-1:0] cnt_q, cnt_d;
  logic          scan_vld_q;
  logic [PB-1:0] scan_idx_q;
  logic          found_q, found_d;
  logic [PB-1:0] best_idx_q, best_idx_d;
  logic [SB-1:0] best_stamp_q, best_stamp_d;
  logic [rlpa_pkg::INDEX_BITS-1:0]  res_granted_q;
  logic [rlpa_pkg::STATUS_BITS-1:0] res_status_q;

  logic [PB-1:0] page_addr;
  logic [PB-1:0] rd_addr;
  logic          in_range;
  logic [RB-1:0] cur_ref;
  logic [SB-1:0] cur_stamp;
  logic [SB-1:0] clock_inc;
  logic [SB-1:0] new_stamp;
  logic [RB-1:0] new_ref;
  logic          is_touch, is_share, is_release;
  logic          we;
  logic [PB-1:0] waddr;
  logic [WB-1:0] wdata;

  assign page_addr  = PB'(page_q);
  assign in_range   = 32'(page_q) < rlpa_pkg::NUM_PAGES;
  assign cur_ref    = rdata_q[WB-1:SB];
  assign cur_stamp  = rdata_q[SB-1:0];
  assign clock_inc  = clock_q + SB'(1);
  assign is_touch   = mode_q == rlpa_pkg::MODE_TOUCH;
  assign is_share   = mode_q == rlpa_pkg::MODE_SHARE;
  assign is_release = mode_q == rlpa_pkg::MODE_RELEASE;
  assign new_stamp  = reuse_q ? clock_q : clock_inc;
  assign rd_addr    = cmd_i.scan_step ? cnt_q : page_addr;

  assign sts_o.cnt_last = cnt_q == PB'(rlpa_pkg::NUM_PAGES - 1);

  // Select the reference count that the page update writes
  always_comb begin
    new_ref = cur_ref;
    if (is_share) begin
      if (cur_ref != '1) new_ref = cur_ref + RB'(1);
    end else if (is_release) begin
      new_ref = cur_ref - RB'(1);
    end
  end

  // Steer the single write port
  always_comb begin
    we    = 1'b0;
    waddr = page_addr;
    wdata = {new_ref, cur_stamp};
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else if (cmd_i.alloc_wr) begin
      we    = found_q;
      waddr = best_idx_q;
      wdata = {RB'(1), clock_inc};
    end else if (cmd_i.page_wr) begin
      we    = in_range && !(is_release && (cur_ref == '0));
      wdata = {new_ref, is_release ? cur_stamp : new_stamp};
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[rd_addr];
  end

  // Advance the stamp clock
  always_comb begin
    clock_d = clock_q;
    if (cmd_i.alloc_wr && found_q) begin
      clock_d = clock_inc;
    end else if (cmd_i.page_wr && in_range && (is_touch || is_share) && !reuse_q) begin
      clock_d = clock_inc;
    end
  end

  // Counter for the clearing pass and the allocation scan
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.latch_in) cnt_d = '0;
    else if (cmd_i.clr_step || cmd_i.scan_step) cnt_d = PB'(cnt_q + PB'(1));
  end

  // Track the oldest unreferenced page, lowest index on ties
  always_comb begin
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    if (cmd_i.latch_in) begin
      found_d = 1'b0;
    end else if (scan_vld_q && (cur_ref == '0)) begin
      if (!found_q || (cur_stamp < best_stamp_q)) begin
        found_d      = 1'b1;
        best_idx_d   = scan_idx_q;
        best_stamp_d = cur_stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q    <= '0;
      cnt_q      <= '0;
      scan_vld_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      clock_q    <= clock_d;
      cnt_q      <= cnt_d;
      scan_vld_q <= cmd_i.scan_step;
      found_q    <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q   <= cnt_q;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    if (cmd_i.latch_in) begin
      mode_q  <= mode_i;
      page_q  <= page_index_i;
      reuse_q <= reuse_stamp_i;
    end
    if (cmd_i.alloc_wr) begin
      res_granted_q <= found_q ? rlpa_pkg::INDEX_BITS'(best_idx_q) : '0;
      res_status_q  <= found_q ? rlpa_pkg::STATUS_OK : rlpa_pkg::STATUS_NO_FREE;
    end else if (cmd_i.page_wr) begin
      res_granted_q <= page_q;
      res_status_q  <= (in_range && is_release && (cur_ref == '0)) ?
                       rlpa_pkg::STATUS_REL_FREE : rlpa_pkg::STATUS_OK;
    end
  end

  assign res_granted_o = res_granted_q;
  assign res_status_o  = res_status_q;

endmodule

// ----- hdl/rlpa_ctrl.sv -----
// Controller of the page allocator: sequences clearing, page updates and scans.
// Depends on rlpa_pkg; commands rlpa_datapath through cmd_t.
module rlpa_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rlpa_pkg::MODE_BITS-1:0]  in_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            emit_o,
  output rlpa_pkg::cmd_t                  cmd_o,
  input  rlpa_pkg::sts_t                  sts_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE_RD,
    ST_PAGE_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   emit;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_ready_o && in_valid_i;
  assign emit        = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  assign emit_o      = emit;
  assign out_valid_o = out_valid_q;

  // Decode commands from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.latch_in  = accept;
    cmd_o.clr_step  = state_q == ST_CLEAR;
    cmd_o.scan_step = state_q == ST_SCAN;
    cmd_o.page_wr   = state_q == ST_PAGE_WR;
    cmd_o.alloc_wr  = state_q == ST_COMMIT;
  end

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_mode_i == rlpa_pkg::MODE_ALLOC) ? ST_SCAN : ST_PAGE_RD;
        end
      end
      ST_PAGE_RD: state_d = ST_PAGE_WR;
      ST_PAGE_WR: state_d = ST_RESP;
      ST_SCAN: begin
        if (sts_i.cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (emit) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/refcounted_lru_page_allocator.sv -----
// Top level of the reference-counted LRU page allocator.
// Depends on rlpa_pkg, rlpa_if, rlpa_ctrl and rlpa_datapath.
//
// One transaction is worked on at a time. Touch, share and release go from acceptance to the
// result register through a read, an update and a hand-off; allocate walks the whole page
// table through the single read port of its memory, one page per cycle, then drains, commits
// the chosen page and hands off. After reset the block sweeps the page table to zero before
// ready rises. A new request is taken while an earlier result still waits in the output
// register.
module refcounted_lru_page_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlpa_req_if.sink   req_i,
  rlpa_rsp_if.source rsp_o
);

  rlpa_pkg::cmd_t cmd;
  rlpa_pkg::sts_t sts;
  logic           emit;
  logic [rlpa_pkg::INDEX_BITS-1:0]  res_granted;
  logic [rlpa_pkg::STATUS_BITS-1:0] res_status;
  logic [rlpa_pkg::INDEX_BITS-1:0]  granted_q;
  logic [rlpa_pkg::STATUS_BITS-1:0] status_q;

  rlpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_mode_i   (req_i.mode),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .emit_o      (emit),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rlpa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (req_i.mode),
    .page_index_i  (req_i.page_index),
    .reuse_stamp_i (req_i.reuse_stamp),
    .res_granted_o (res_granted),
    .res_status_o  (res_status)
  );

  // Load the output register when the result is handed off
  always_ff @(posedge clk_i) begin
    if (emit) begin
      granted_q <= res_granted;
      status_q  <= res_status;
    end
  end

  assign rsp_o.granted_page = granted_q;
  assign rsp_o.status       = status_q;

endmodule

// ----- hdl/rlpa_checker.sv -----
// Port-level checks for the page allocator, attached to the top level by bind.
// Depends on rlpa_pkg for widths and status codes.
module rlpa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [rlpa_pkg::INDEX_BITS-1:0]   granted_page_i,
  input logic [rlpa_pkg::STATUS_BITS-1:0]  status_i
);

  // One transaction at a time: ready drops after an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another transaction is in progress");

  // A failed allocation grants page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i == rlpa_pkg::STATUS_NO_FREE)) |-> (granted_page_i == '0))
    else $error("failed allocation reports a nonzero page");

  // Only defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((status_i == rlpa_pkg::STATUS_OK) ||
                     (status_i == rlpa_pkg::STATUS_NO_FREE) ||
                     (status_i == rlpa_pkg::STATUS_REL_FREE)))
    else $error("undefined status code");

  // A stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(granted_page_i) && $stable(status_i)))
    else $error("stalled response changed");

endmodule

bind refcounted_lru_page_allocator rlpa_checker u_rlpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .granted_page_i (rsp_o.granted_page),
  .status_i       (rsp_o.status)
);

// ----- tb/sv/tb.sv -----
// Testbench for the reference-counted LRU page allocator: a directed table, then random
// page traffic, each response checked against its typed row or an in-bench pool model.
// Depends on rlpa_pkg, rlpa_if and refcounted_lru_page_allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUEST_TARGET = 1220;
  localparam int QUIET_TAIL     = 150;
  localparam int N_DIRECTED     = 20;
  localparam int EXP_DEPTH      = 16;
  localparam int HELD_DEPTH     = 8;

  typedef struct packed {
    logic [rlpa_pkg::INDEX_BITS-1:0] granted_page;
    rlpa_pkg::status_e               status;
  } page_result_t;

  typedef struct packed {
    rlpa_pkg::mode_e                 mode;
    logic [rlpa_pkg::INDEX_BITS-1:0] page;
    logic                            reuse;
    logic                            typed;
    logic [rlpa_pkg::INDEX_BITS-1:0] exp_page;
    rlpa_pkg::status_e               exp_status;
  } directed_row_t;

  logic clk;
  logic rst_n;

  rlpa_req_if req ();
  rlpa_rsp_if rsp ();

  refcounted_lru_page_allocator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Model of the page pool
  logic [rlpa_pkg::REF_BITS-1:0]   page_refs  [rlpa_pkg::NUM_PAGES];
  logic [rlpa_pkg::STAMP_BITS-1:0] page_stamp [rlpa_pkg::NUM_PAGES];
  logic [rlpa_pkg::STAMP_BITS-1:0] stamp_now;

  // Expected responses in order; the stimulus side advances exp_wr, the checker exp_rd
  page_result_t exp_fifo [EXP_DEPTH];
  int           exp_wr;
  int           exp_rd;
  int           mismatch_count;
  int           requests_issued;
  bit           idle_en;

  // Known page table state after reset, start with a clean bench
  initial begin
    for (int p = 0; p < rlpa_pkg::NUM_PAGES; p++) begin
      page_refs[p]  = '0;
      page_stamp[p] = '0;
    end
    stamp_now       = '0;
    exp_wr          = 0;
    exp_rd          = 0;
    mismatch_count  = 0;
    requests_issued = 0;
    idle_en         = 1'b0;
  end

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Random page number over the whole field
  function automatic logic [rlpa_pkg::INDEX_BITS-1:0] rand_page();
    return rlpa_pkg::INDEX_BITS'($urandom_range(0, 255));
  endfunction

  // Random single bit
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Apply one request to the pool model and return the response it must produce
  function automatic page_result_t apply_page_op(rlpa_pkg::mode_e m,
                                                 logic [rlpa_pkg::INDEX_BITS-1:0] pg,
                                                 logic reuse);
    page_result_t res;
    bit           found;
    int           best;
    res.granted_page = pg;
    res.status       = rlpa_pkg::STATUS_OK;
    found            = 1'b0;
    best             = 0;
    if (m == rlpa_pkg::MODE_ALLOC) begin
      for (int p = 0; p < rlpa_pkg::NUM_PAGES; p++) begin
        if (page_refs[p] == '0 && (!found || page_stamp[p] < page_stamp[best])) begin
          best  = p;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.granted_page = '0;
        res.status       = rlpa_pkg::STATUS_NO_FREE;
      end else begin
        stamp_now        = stamp_now + 1'b1;
        page_refs[best]  = 8'd1;
        page_stamp[best] = stamp_now;
        res.granted_page = best[rlpa_pkg::INDEX_BITS-1:0];
      end
    end else if (int'(pg) < rlpa_pkg::NUM_PAGES) begin
      if (m == rlpa_pkg::MODE_RELEASE) begin
        if (page_refs[pg] == '0) res.status = rlpa_pkg::STATUS_REL_FREE;
        else page_refs[pg] = page_refs[pg] - 1'b1;
      end else begin
        if (m == rlpa_pkg::MODE_SHARE && page_refs[pg] != '1)
          page_refs[pg] = page_refs[pg] + 1'b1;
        if (!reuse) stamp_now = stamp_now + 1'b1;
        page_stamp[pg] = stamp_now;
      end
    end
    return res;
  endfunction

  // Random page that holds a reference, or any page when none does
  function automatic logic [rlpa_pkg::INDEX_BITS-1:0] pick_referenced_page();
    int start;
    int p;
    start = $urandom_range(0, rlpa_pkg::NUM_PAGES - 1);
    for (int k = 0; k < rlpa_pkg::NUM_PAGES; k++) begin
      p = (start + k) % rlpa_pkg::NUM_PAGES;
      if (page_refs[p] != '0) return p[rlpa_pkg::INDEX_BITS-1:0];
    end
    return start[rlpa_pkg::INDEX_BITS-1:0];
  endfunction

  // Drive one request, hold it until accepted, then store its expected response
  task automatic send_request(input rlpa_pkg::mode_e m,
                              input logic [rlpa_pkg::INDEX_BITS-1:0] pg,
                              input logic reuse, input logic typed,
                              input page_result_t typed_res, output page_result_t res);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.page_index  <= pg;
    req.reuse_stamp <= reuse;
    do @(posedge clk); while (!req.ready);
    res = apply_page_op(m, pg, reuse);
    exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_res : res;
    exp_wr++;
    requests_issued++;
  endtask

  // Response side: check each transaction, stall in random bursts
  initial begin
    int           stall_left;
    page_result_t want;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (exp_wr == exp_rd) begin
          mismatch_count++;
          $display("%0t: unexpected response: page %0d status %0d", $time,
                   rsp.granted_page, rsp.status);
        end else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (rsp.granted_page !== want.granted_page) begin
            mismatch_count++;
            $display("%0t: granted_page mismatch: expected %0d, actual %0d", $time,
                     want.granted_page, rsp.granted_page);
          end
          if (rsp.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch: expected %0d (%s), actual %0d", $time,
                     want.status, want.status.name(), rsp.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Directed table: fresh pool allocations, release errors, every mode and field extreme
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{rlpa_pkg::MODE_ALLOC,   8'd0,   1'b0, 1'b1, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_ALLOC,   8'd77,  1'b1, 1'b1, 8'd1,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd200, 1'b0, 1'b1, 8'd200, rlpa_pkg::STATUS_REL_FREE},
    '{rlpa_pkg::MODE_RELEASE, 8'd0,   1'b0, 1'b1, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_ALLOC,   8'd255, 1'b0, 1'b1, 8'd2,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_TOUCH,   8'd255, 1'b0, 1'b1, 8'd255, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_TOUCH,   8'd85,  1'b1, 1'b1, 8'd85,  rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_SHARE,   8'd170, 1'b1, 1'b1, 8'd170, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_SHARE,   8'd255, 1'b0, 1'b1, 8'd255, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd255, 1'b1, 1'b1, 8'd255, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd255, 1'b0, 1'b1, 8'd255, rlpa_pkg::STATUS_REL_FREE},
    '{rlpa_pkg::MODE_ALLOC,   8'd0,   1'b1, 1'b0, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_TOUCH,   8'd0,   1'b0, 1'b0, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd1,   1'b0, 1'b1, 8'd1,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_ALLOC,   8'd170, 1'b0, 1'b0, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_SHARE,   8'd0,   1'b0, 1'b0, 8'd0,   rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd170, 1'b0, 1'b1, 8'd170, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_RELEASE, 8'd170, 1'b0, 1'b1, 8'd170, rlpa_pkg::STATUS_REL_FREE},
    '{rlpa_pkg::MODE_TOUCH,   8'd128, 1'b0, 1'b0, 8'd128, rlpa_pkg::STATUS_OK},
    '{rlpa_pkg::MODE_ALLOC,   8'd85,  1'b1, 1'b0, 8'd0,   rlpa_pkg::STATUS_OK}
  };

  // Stimulus and end of run
  initial begin
    page_result_t                    got;
    page_result_t                    typed_res;
    logic [rlpa_pkg::INDEX_BITS-1:0] held [HELD_DEPTH];
    int                              held_n;
    logic [rlpa_pkg::INDEX_BITS-1:0] sat_page;
    int                              full_at;
    bit                              full_done;
    int                              seg_len;
    int                              pick;
    int                              idx;

    rst_n           <= 1'b0;
    req.valid       <= 1'b0;
    req.mode        <= rlpa_pkg::MODE_TOUCH;
    req.page_index  <= '0;
    req.reuse_stamp <= 1'b0;
    held_n          = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    idle_en = 1'b1;
    foreach (directed_rows[i]) begin
      typed_res.granted_page = directed_rows[i].exp_page;
      typed_res.status       = directed_rows[i].exp_status;
      send_request(directed_rows[i].mode, directed_rows[i].page, directed_rows[i].reuse,
                   directed_rows[i].typed, typed_res, got);
    end

    // Random traffic in segments; one segment drives the pool full
    typed_res = '0;
    full_done = 1'b0;
    full_at   = $urandom_range(150, 350);
    while (requests_issued < REQUEST_TARGET) begin
      idle_en = (requests_issued < REQUEST_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (!full_done && requests_issued >= full_at) begin
        // Saturate one page, reference the rest, fail allocates, then free all but it
        full_done = 1'b1;
        sat_page  = rlpa_pkg::INDEX_BITS'($urandom_range(0, rlpa_pkg::NUM_PAGES - 1));
        repeat (256) send_request(rlpa_pkg::MODE_SHARE, sat_page, rand_bit(), 1'b0,
                                  typed_res, got);
        for (int p = 0; p < rlpa_pkg::NUM_PAGES; p++) begin
          if (page_refs[p] == '0)
            send_request(rlpa_pkg::MODE_SHARE, p[rlpa_pkg::INDEX_BITS-1:0], rand_bit(),
                         1'b0, typed_res, got);
        end
        send_request(rlpa_pkg::MODE_ALLOC, rand_page(), rand_bit(), 1'b0, typed_res, got);
        send_request(rlpa_pkg::MODE_TOUCH, rand_page(), 1'b0, 1'b0, typed_res, got);
        send_request(rlpa_pkg::MODE_ALLOC, rand_page(), rand_bit(), 1'b0, typed_res, got);
        for (int p = 0; p < rlpa_pkg::NUM_PAGES; p++) begin
          while (p != int'(sat_page) && page_refs[p] != '0)
            send_request(rlpa_pkg::MODE_RELEASE, p[rlpa_pkg::INDEX_BITS-1:0], rand_bit(),
                         1'b0, typed_res, got);
        end
      end else if ($urandom_range(0, 2) == 0) begin
        // Allocate a few pages, touch around them, release them in random order
        repeat ($urandom_range(1, HELD_DEPTH)) begin
          send_request(rlpa_pkg::MODE_ALLOC, rand_page(), rand_bit(), 1'b0, typed_res, got);
          if (got.status == rlpa_pkg::STATUS_OK) begin
            held[held_n] = got.granted_page;
            held_n++;
          end
          if ($urandom_range(0, 1) == 0)
            send_request(rlpa_pkg::MODE_TOUCH, rand_page(), rand_bit(), 1'b0, typed_res, got);
        end
        while (held_n != 0) begin
          idx = $urandom_range(0, held_n - 1);
          send_request(rlpa_pkg::MODE_RELEASE, held[idx], rand_bit(), 1'b0, typed_res, got);
          held[idx] = held[held_n - 1];
          held_n--;
        end
      end else begin
        // Mixed traffic, releases mostly and shares half the time on live pages
        seg_len = $urandom_range(16, 48);
        repeat (seg_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 25)
            send_request(rlpa_pkg::MODE_ALLOC, rand_page(), rand_bit(), 1'b0, typed_res, got);
          else if (pick < 45)
            send_request(rlpa_pkg::MODE_SHARE,
                         ($urandom_range(0, 1) == 0) ? pick_referenced_page() : rand_page(),
                         rand_bit(), 1'b0, typed_res, got);
          else if (pick < 75)
            send_request(rlpa_pkg::MODE_RELEASE,
                         ($urandom_range(0, 9) < 7) ? pick_referenced_page() : rand_page(),
                         rand_bit(), 1'b0, typed_res, got);
          else
            send_request(rlpa_pkg::MODE_TOUCH, rand_page(), rand_bit(), 1'b0, typed_res, got);
        end
      end
    end

    // Drain, then leave room for any stray response
    idle_en = 1'b0;
    req.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (rlpa_pkg::NUM_PAGES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
